### hw/rtl/ipv4p_pkg.sv
// Types, character codes and helper functions shared by the IPv4 address parser.
`default_nettype none

package ipv4p_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PART,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [31:0] MASK_24 = 32'h00ffffff;
	localparam logic [31:0] MASK_16 = 32'h0000ffff;
	localparam logic [31:0] MASK_8  = 32'h000000ff;

	// Parser state carried from one character to the next.
	typedef struct packed {
		phase_t            phase;
		base_t             base;
		logic [31:0]       value;
		logic [1:0]        count;
		logic [2:0][31:0]  parts;
	} parse_state_t;

	// Outcome of one character.
	typedef struct packed {
		logic        emit;
		logic        ok;
		logic [31:0] address;
	} parse_result_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ipv4_dotted_address_parser.sv
// Top level of the streaming IPv4 dotted address parser.
//
//   Channel  Direction  Handshake               Payload
//   in       to block   in_valid / in_stall     char_code[7:0], string_start
//   out      from block out_valid / out_stall   parse_ok, address[31:0]
//
// One character is taken per cycle while the input is not stalled. A character
// sits in the input register while the parser logic folds it into the state, and
// the result that it settles is then loaded into the output register, from which
// it can be taken.
// Reset (arst_n low) clears the parser to its finished phase and empties both
// registers. A stalled output holds the input register, which stalls the input.
`default_nettype none

module ipv4_dotted_address_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        string_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             parse_ok,
	output logic [31:0]      address
);
	import ipv4p_pkg::*;

	logic          valid_s1;
	logic [7:0]    char_s1;
	logic          start_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res;
	logic          can_advance;
	logic          proc_s1;
	logic          out_valid_q;
	logic          parse_ok_q;
	logic [31:0]   address_q;

	// The stage behind the input register moves whenever the output register
	// is empty or is being emptied in this cycle.
	assign can_advance = !out_valid_q || !out_stall;
	assign proc_s1     = valid_s1 && can_advance;
	assign in_stall    = valid_s1 && !can_advance;

	ipv4p_step u_step (
		.char_code    (char_s1),
		.string_start (start_s1),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1  <= char_code;
			start_s1 <= string_start;
		end
	end

	// Parser state advances once per processed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, base: BASE_DEC, value: 32'd0,
				count: 2'd0, parts: '0};
		end else if (proc_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register: loads a settled result, drops a taken one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_advance) begin
			out_valid_q <= proc_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && res.emit) begin
			parse_ok_q <= res.ok;
			address_q  <= res.address;
		end
	end

	assign out_valid = out_valid_q;
	assign parse_ok  = parse_ok_q;
	assign address   = address_q;

	// A failed parse always reports a zero address.
	a_err_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (parse_ok || (address == 32'd0)))
		else $error("error result with nonzero address");

	// An item held by a stalled output stays in the input register.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_advance) |=> valid_s1)
		else $error("input register lost an item under stall");

	// Once a result is given the parser waits for the next string.
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_s1 && res.emit) |=> (state_q.phase == PH_IDLE))
		else $error("parser not finished after giving a result");

	// The output register only loads from a processed character.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !proc_s1) |=> !out_valid)
		else $error("result appeared without a processed character");

endmodule

`default_nettype wire

### hw/rtl/ipv4p_step.sv
// Next-state and result logic for one character of the address parser.
`default_nettype none

module ipv4p_step (
	input  wire logic [7:0]              char_code,
	input  wire logic                    string_start,
	input  wire ipv4p_pkg::parse_state_t cur,
	output ipv4p_pkg::parse_state_t      nxt,
	output ipv4p_pkg::parse_result_t     res
);
	import ipv4p_pkg::*;

	phase_t      ph_e;
	logic [1:0]  cnt_e;
	logic [31:0] dv;
	base_t       db;
	logic        c_dec;
	logic        c_hexl;
	logic        c_dot;
	logic        c_end;
	logic        c_x;
	logic        dot_ok;
	logic [31:0] dec_val;
	logic [31:0] hex_val;
	logic        fits;
	logic [31:0] addr;

	// A start character restarts parsing from the first part.
	assign ph_e  = string_start ? PH_PART : cur.phase;
	assign cnt_e = string_start ? 2'd0 : cur.count;

	// After a leading zero the part restarts at zero in octal.
	assign dv = (ph_e == PH_ZERO) ? 32'd0 : cur.value;
	assign db = (ph_e == PH_ZERO) ? BASE_OCT : cur.base;

	assign c_dec  = is_dec(char_code);
	assign c_hexl = (db == BASE_HEX) &&
		(((char_code >= CH_LA) && (char_code <= CH_LF)) ||
		 ((char_code >= CH_UA) && (char_code <= CH_UF)));
	assign c_dot  = (char_code == CH_DOT);
	assign c_end  = (char_code == CH_NUL) || is_space(char_code);
	assign c_x    = (char_code == CH_LX) || (char_code == CH_UX);
	assign dot_ok = c_dot && (cnt_e != 2'd3);

	always_comb begin
		unique case (db)
			BASE_HEX: dec_val = {dv[27:0], 4'b0} + {28'd0, char_code[3:0]};
			BASE_OCT: dec_val = {dv[28:0], 3'b0} + {28'd0, char_code[3:0]};
			default:  dec_val = {dv[28:0], 3'b0} + {dv[30:0], 1'b0} +
				{28'd0, char_code[3:0]};
		endcase
	end

	// Letters a-f and A-F share their low nibble; the digit is that nibble plus nine.
	assign hex_val = {dv[27:0], 4'b0} | {28'd0, char_code[3:0] + 4'd9};

	always_comb begin
		unique case (cnt_e)
			2'd0: begin
				fits = 1'b1;
				addr = dv;
			end
			2'd1: begin
				fits = (dv & ~MASK_24) == 32'd0;
				addr = dv | {cur.parts[0][7:0], 24'd0};
			end
			2'd2: begin
				fits = (dv & ~MASK_16) == 32'd0;
				addr = dv | {cur.parts[0][7:0], 24'd0} | {cur.parts[1][15:0], 16'd0};
			end
			default: begin
				fits = (dv & ~MASK_8) == 32'd0;
				addr = dv | {cur.parts[0][7:0], 24'd0} | {cur.parts[1][15:0], 16'd0}
					| {cur.parts[2][23:0], 8'd0};
			end
		endcase
	end

	// Next state.
	always_comb begin
		nxt       = cur;
		nxt.count = cnt_e;
		unique case (ph_e)
			PH_PART: begin
				if (c_dec) begin
					nxt.value = {28'd0, char_code[3:0]};
					nxt.base  = BASE_DEC;
					nxt.phase = (char_code == CH_ZERO) ? PH_ZERO : PH_DIGITS;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			PH_ZERO, PH_DIGITS: begin
				nxt.phase = PH_DIGITS;
				nxt.base  = db;
				nxt.value = dv;
				priority if ((ph_e == PH_ZERO) && c_x) begin
					nxt.base = BASE_HEX;
				end else if (c_dec) begin
					nxt.value = dec_val;
				end else if (c_hexl) begin
					nxt.value = hex_val;
				end else if (dot_ok) begin
					nxt.parts[cnt_e] = dv;
					nxt.count        = cnt_e + 2'd1;
					nxt.phase        = PH_PART;
				end else begin
					nxt.phase = PH_IDLE;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
	end

	// Result of this character.
	always_comb begin
		res = '0;
		unique case (ph_e)
			PH_PART: begin
				res.emit = !c_dec;
			end
			PH_ZERO, PH_DIGITS: begin
				res.emit = !((ph_e == PH_ZERO) && c_x) && !c_dec && !c_hexl && !dot_ok;
				res.ok   = c_end && fits;
				res.address = (c_end && fits) ? addr : 32'd0;
			end
			default: begin
				res.emit = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### bench/ipv4_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the IPv4 dotted address parser: predicts and compares every result.
module ipv4_result_checker
	import ipv4p_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        string_start,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        parse_ok,
	input  logic [31:0] address,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic        ok;
		logic [31:0] addr;
	} addr_result_t;

	// Shadow copy of the parser state.
	phase_t       ph;
	base_t        radix;
	logic [31:0]  part_val;
	logic [31:0]  done_parts [3];
	logic [1:0]   n_parts;
	addr_result_t address_q[$];
	int           errs;

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic settle(input logic ok, input logic [31:0] addr);
		addr_result_t r;
		r.ok = ok;
		r.addr = ok ? addr : 32'd0;
		address_q.push_back(r);
		ph = PH_IDLE;
	endtask

	// The last part fills whatever the earlier parts left free.
	task automatic close_address();
		logic [31:0] v;
		v = part_val;
		case (n_parts)
			2'd0: settle(1'b1, v);
			2'd1: begin
				if (v > MASK_24)
					settle(1'b0, 32'd0);
				else
					settle(1'b1, v | (done_parts[0] << 24));
			end
			2'd2: begin
				if (v > MASK_16)
					settle(1'b0, 32'd0);
				else
					settle(1'b1, v | (done_parts[0] << 24) | (done_parts[1] << 16));
			end
			default: begin
				if (v > MASK_8)
					settle(1'b0, 32'd0);
				else
					settle(1'b1, v | (done_parts[0] << 24) | (done_parts[1] << 16)
						| (done_parts[2] << 8));
			end
		endcase
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [31:0] mul;
		mul = (radix == BASE_HEX) ? 32'd16 : ((radix == BASE_OCT) ? 32'd8 : 32'd10);
		if (is_digit(c))
			part_val = part_val * mul + 32'(c - CH_ZERO);
		else if (radix == BASE_HEX && c >= CH_LA && c <= CH_LF)
			part_val = (part_val << 4) | 32'(c - CH_LA + 8'd10);
		else if (radix == BASE_HEX && c >= CH_UA && c <= CH_UF)
			part_val = (part_val << 4) | 32'(c - CH_UA + 8'd10);
		else if (c == CH_DOT) begin
			if (n_parts == 2'd3)
				settle(1'b0, 32'd0);
			else begin
				done_parts[n_parts] = part_val;
				n_parts = n_parts + 2'd1;
				ph = PH_PART;
			end
		end else if (c != CH_NUL && !is_blank(c))
			settle(1'b0, 32'd0);
		else
			close_address();
	endtask

	task automatic fold_char(input logic [7:0] c, input logic s);
		if (s) begin
			part_val = '0;
			radix = BASE_DEC;
			done_parts = '{default: '0};
			n_parts = '0;
			ph = PH_PART;
		end
		case (ph)
			PH_PART: begin
				if (!is_digit(c))
					settle(1'b0, 32'd0);
				else begin
					part_val = 32'(c - CH_ZERO);
					radix = BASE_DEC;
					ph = (c == CH_ZERO) ? PH_ZERO : PH_DIGITS;
				end
			end
			PH_ZERO: begin
				part_val = '0;
				ph = PH_DIGITS;
				if (c == CH_LX || c == CH_UX)
					radix = BASE_HEX;
				else begin
					radix = BASE_OCT;
					take_digit(c);
				end
			end
			PH_DIGITS: take_digit(c);
			default: ph = PH_IDLE;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		addr_result_t got;
		addr_result_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			radix = BASE_DEC;
			part_val = '0;
			done_parts = '{default: '0};
			n_parts = '0;
			address_q.delete();
			errs = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				fold_char(char_code, string_start);
			if (out_valid && !out_stall) begin
				got.ok = parse_ok;
				got.addr = address;
				if (address_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: unexpected result parse_ok=%0b address=%h",
							$realtime, got.ok, got.addr);
				end else begin
					want = address_q.pop_front();
					if (got.ok !== want.ok || got.addr !== want.addr) begin
						errs++;
						if (errs <= 10)
							$display("%0t: mismatch parse_ok exp %0b got %0b, address exp %h got %h",
								$realtime, want.ok, got.ok, want.addr, got.addr);
					end
				end
			end
			mismatches <= errs;
			pending <= address_q.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the IPv4 dotted address parser bench: clock, reset, character stimulus and verdict.
module tb_top;
	import ipv4p_pkg::*;

	// The run is cut off here.
	localparam int LIMIT_CYCLES = 600000;
	// Characters that belong to strings; ignored tail characters are not counted.
	localparam int ITEM_TARGET = 1500;
	// Length of the long receiver hold-off that fills the block up.
	localparam int HOLD_CYCLES = 400;
	localparam int NO_END = -1;

	// Whitespace codes that the package does not name.
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_VT = 8'h0b;
	localparam logic [7:0] CH_FF = 8'h0c;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = '0;
	logic        string_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        parse_ok;
	logic [31:0] address;

	int mismatches;
	int pending;
	int cycle_count = 0;
	int items_sent = 0;
	int rx_hold = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit pressure_done = 1'b0;

	// Characters of the string being assembled, sent as one burst of items.
	logic [7:0] txt[$];

	ipv4_dotted_address_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.string_start (string_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.parse_ok     (parse_ok),
		.address      (address)
	);

	ipv4_result_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.string_start (string_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.parse_ok     (parse_ok),
		.address      (address),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("** ipv4_dotted_address_parser: FAILED **");
			$finish;
		end
	end

	// Wait before one item. In a calm stretch there is no idling at all; otherwise
	// half the items go straight through and the rest draw a random wait.
	function automatic int draw_wait(input bit calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Offers one character and returns at the edge where it was taken. Valid stays
	// high afterwards, so the next call either lowers it for a gap or replaces the
	// payload in place.
	task automatic send_item(input logic [7:0] c, input logic s, input bit counted);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		string_start <= s;
		do @(posedge clk); while (in_stall);
		if (counted)
			items_sent++;
	endtask

	// Sends the assembled string, flagging its first character as a new string.
	task automatic flush_string();
		foreach (txt[i])
			send_item(txt[i], i == 0, 1'b1);
		txt.delete();
	endtask

	// A literal string plus an optional ending character, which may be NUL.
	task automatic send_text(input string s, input int term);
		txt.delete();
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		if (term >= 0)
			txt.push_back(term[7:0]);
		flush_string();
	endtask

	// Lowers valid and waits until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [7:0] digit_code(input int k);
		if (k < 10)
			return CH_ZERO + 8'(k);
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(k - 10);
	endfunction

	// Appends v in the given radix without a prefix, most significant digit first.
	task automatic push_digits(input logic [31:0] v, input int radix);
		logic [7:0]  d[$];
		logic [31:0] rest;
		rest = v;
		do begin
			d.push_front(digit_code(int'(rest % radix)));
			rest = rest / radix;
		end while (rest != 0);
		foreach (d[i])
			txt.push_back(d[i]);
	endtask

	// A long run of random digits, so that the part value wraps past 32 bits.
	// Octal parts get 8 and 9 too, which the parser accepts.
	task automatic push_long_digits(input int radix, input int n);
		repeat (n)
			txt.push_back(digit_code($urandom_range(0, (radix == 16) ? 15 : 9)));
	endtask

	// One part meant for a slot of slot_bits bits. Values sit mostly inside the
	// slot, with its edges, one past it, full 32-bit values and wrapping runs mixed in.
	task automatic add_part(input int slot_bits);
		logic [31:0] top_val;
		logic [31:0] v;
		int          form;
		int          pick;
		int          radix;
		top_val = (slot_bits == 32) ? 32'hffffffff : ((32'd1 << slot_bits) - 32'd1);
		form = $urandom_range(0, 5);
		radix = (form == 4) ? 8 : ((form == 5) ? 16 : 10);
		if (form == 4)
			txt.push_back(CH_ZERO);
		else if (form == 5) begin
			txt.push_back(CH_ZERO);
			txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
		end
		pick = $urandom_range(0, 15);
		if (pick == 0)
			v = '0;
		else if (pick == 1)
			v = top_val;
		else if (pick == 2)
			v = top_val + 32'd1;
		else if (pick == 3)
			v = $urandom;
		else if (pick == 5)
			v = $urandom & top_val;
		else
			v = $urandom_range(0, 255) & top_val;
		if (pick == 4)
			push_long_digits(radix, $urandom_range(9, 14));
		else if (form == 5 && $urandom_range(0, 7) == 0) begin
			// Bare hex prefix: the part counts as zero.
		end else begin
			push_digits(v, radix);
			if (form == 4 && $urandom_range(0, 5) == 0)
				txt.push_back(CH_ZERO + 8'($urandom_range(8, 9)));
		end
	endtask

	// A dotted address of one to four parts (five when extra is set, which the
	// parser rejects), ended by NUL, some whitespace, or now and then any byte.
	task automatic well_formed(input bit extra);
		int n;
		int pick;
		n = extra ? 4 : $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			add_part((i == n - 1) ? 32 - 8 * i : 8);
			if (i < n - 1)
				txt.push_back(CH_DOT);
		end
		if (extra) begin
			txt.push_back(CH_DOT);
			add_part(8);
		end
		pick = $urandom_range(0, 8);
		case (pick)
			0, 7: txt.push_back(CH_NUL);
			1: txt.push_back(CH_SPACE);
			2: txt.push_back(CH_TAB);
			3: txt.push_back(CH_NL);
			4: txt.push_back(CH_VT);
			5: txt.push_back(CH_FF);
			6: txt.push_back(CH_CR);
			default: txt.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	// A character drawn from the classes the parser tells apart.
	function automatic logic [7:0] any_char();
		case ($urandom_range(0, 5))
			0: return CH_ZERO + 8'($urandom_range(0, 9));
			1: return CH_DOT;
			2: return $urandom_range(0, 1) ? CH_LX : CH_UX;
			3: return CH_LA + 8'($urandom_range(0, 5));
			4: return CH_SPACE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One random string. Most are well formed with random content; the rest are
	// five-part strings, character soup, strings cut short and abandoned by the
	// next start, and strings that open with a non-digit.
	task automatic random_string();
		int kind;
		int n;
		bit ended;
		kind = $urandom_range(0, 19);
		ended = 1'b1;
		txt.delete();
		if (kind < 13)
			well_formed(1'b0);
		else if (kind < 15)
			well_formed(1'b1);
		else if (kind < 17) begin
			n = $urandom_range(1, 8);
			repeat (n) txt.push_back(any_char());
			if ($urandom_range(0, 1))
				txt.push_back(CH_NUL);
			else
				ended = 1'b0;
		end else if (kind < 19) begin
			well_formed(1'b0);
			n = $urandom_range(1, txt.size() - 1);
			repeat (n) void'(txt.pop_back());
			ended = 1'b0;
		end else begin
			case ($urandom_range(0, 4))
				0: txt.push_back(CH_DOT);
				1: txt.push_back(CH_LA);
				2: txt.push_back(CH_SPACE);
				3: txt.push_back(CH_NUL);
				default: txt.push_back(8'($urandom_range(128, 255)));
			endcase
			txt.push_back(CH_ZERO + 8'd1);
			txt.push_back(CH_NUL);
		end
		flush_string();
		// Characters after the end of a string, without a start flag, are dropped.
		if (ended && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3))
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	// Receiver: a stall of random length before each result, or once the long
	// hold-off, counted here in cycles while the sender keeps offering items.
	initial begin : rx_side
		int n;
		forever begin
			if (rx_hold != 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else
				n = draw_wait(rx_calm);
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : tx_side
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: field extremes, every number form and each error kind.
		send_text("255.255.255.255", CH_NUL);
		send_text("0.0.0.0", CH_SPACE);
		send_text("0x", CH_NUL);                // bare hex prefix gives zero
		send_text("0XfF.0377.9.1", CH_TAB);
		send_text("089", CH_NL);                // octal part with 8 and 9
		send_text("0xABCDEF01", CH_VT);
		send_text("", CH_NUL);                  // empty string, missing digit
		send_text("", 8'hff);                   // code above 127 as first character
		send_text("1.", CH_NUL);                // trailing dot
		send_text("1.2.3.4.5", CH_NUL);         // fifth part
		send_text("1.2.3.4x", CH_NUL);          // bad trailing character
		send_text("19", 8'h80);                 // high code ends a part
		send_text("1.2.3.256", CH_FF);          // last part too big for 8 bits
		send_text("1.2.65536", CH_CR);          // too big for 16 bits
		send_text("1.16777216", CH_NUL);        // too big for 24 bits
		send_text("1.16777215", CH_NUL);
		send_text("4294967295", CH_NUL);
		send_text("4294967296", CH_NUL);        // wraps to zero
		send_text("300.1.2.3", CH_NUL);         // oversized earlier part merges
		send_text("12.3", NO_END);              // abandoned by the next start
		send_text("7", CH_NUL);
		send_item(CH_ZERO, 1'b0, 1'b0);         // ignored while finished

		while (items_sent < ITEM_TARGET) begin
			// Now and then switch either side into or out of a stretch without idling.
			if ($urandom_range(0, 31) == 0) begin
				tx_calm = ($urandom_range(0, 2) == 0);
				rx_calm = ($urandom_range(0, 2) == 0);
			end
			// Halfway through, hold the receiver off while characters keep coming at
			// full rate, so that the block fills up and stalls its input; then pause
			// until everything predicted so far has come out.
			if (!pressure_done && items_sent > ITEM_TARGET / 2) begin
				rx_hold = HOLD_CYCLES;
				tx_calm = 1'b1;
				repeat (30) begin
					txt.delete();
					well_formed(1'b0);
					flush_string();
				end
				tx_calm = 1'b0;
				drain();
				pressure_done = 1'b1;
			end
			random_string();
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("** ipv4_dotted_address_parser: PASSED **");
		else
			$display("** ipv4_dotted_address_parser: FAILED **");
		$finish;
	end

endmodule
